// ===== rtl/gbi_pkg.sv =====
package gbi_pkg;

  localparam int unsigned GRID_WORDS   = 65536;
  localparam int unsigned MAX_DIM      = 4096;
  localparam int unsigned MAX_CHANNELS = 16;
  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned IDX_W        = 12;
  localparam int unsigned CNT_W        = 13;
  localparam int unsigned CH_W         = 4;
  localparam int unsigned N_W          = 5;
  localparam int unsigned BASE_W       = 28;
  localparam int unsigned FILL_STEPS   = 2;

  typedef enum logic [2:0] {
    CFG_WEST   = 3'd0,
    CFG_TOP    = 3'd1,
    CFG_INV_W  = 3'd2,
    CFG_INV_H  = 3'd3,
    CFG_ROWS   = 3'd4,
    CFG_COLS   = 3'd5,
    CFG_CHANS  = 3'd6,
    CFG_NODATA = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_BASE1,
    B_BASE2,
    B_RD,
    B_FILL,
    B_AC,
    B_BD,
    B_X,
    B_NOD
  } back_state_e;

  typedef struct packed {
    logic signed [47:0] west;
    logic signed [47:0] top;
    logic [47:0]        inv_w;
    logic [47:0]        inv_h;
    logic [CNT_W-1:0]   rows;
    logic [CNT_W-1:0]   cols;
    logic [N_W-1:0]     chans;
    logic signed [31:0] nod;
  } cfg_t;

  typedef struct packed {
    logic               is_write;
    logic [15:0]        waddr;
    logic [31:0]        wdata;
    logic [IDX_W-1:0]   ri;
    logic [IDX_W-1:0]   ci;
    logic               di;
    logic               dj;
    logic [15:0]        dr;
    logic [15:0]        dc;
    logic [1:0]         flags;
    logic               nod_only;
    logic [CH_W-1:0]    first;
    logic [N_W-1:0]     n;
  } job_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [15:0]      frac;
    logic             clamp;
  } loc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic loc_t locate(logic neg, logic [47:0] inv, logic [95:0] acc,
                                  logic [IDX_W-1:0] maxidx);
    loc_t r;
    r.idx   = acc[48+IDX_W-1:48];
    r.frac  = acc[47:32];
    r.clamp = 1'b0;
    if ((neg && inv != 48'd0) || (acc[95:48] >= {{(48-IDX_W){1'b0}}, maxidx})) begin
      r.clamp = 1'b1;
      r.frac  = 16'd0;
      r.idx   = neg && inv != 48'd0 ? '0 : maxidx;
    end
    return r;
  endfunction

endpackage

// ===== rtl/gbi_front.sv =====
module gbi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gbi_pkg::cfg_t       cfg_i,
  input  logic                start,
  output logic                busy,
  input  logic                action_i,
  input  logic signed [47:0]  northing_i,
  input  logic signed [47:0]  easting_i,
  input  logic                extrapolate_i,
  input  logic [3:0]          first_channel_i,
  input  logic [4:0]          channel_span_i,
  input  logic [15:0]         word_address_i,
  input  logic signed [31:0]  word_value_i,
  input  gbi_pkg::fifo_status_t fifo_i,
  output logic                push_o,
  output gbi_pkg::job_t       job_o
);

  gbi_pkg::front_state_e state_q, state_d;
  logic [2:0]            cnt_q;
  logic signed [48:0]    diff_r_q, diff_c_q;
  logic [95:0]           acc_q, acc_d;
  logic                  extra_q;
  gbi_pkg::job_t         job_q;
  logic                  accept;
  logic [47:0]           m_sel, inv_sel;
  logic [15:0]           chunk;
  logic [1:0]            csel;
  logic [gbi_pkg::IDX_W-1:0] maxr, maxc;
  gbi_pkg::loc_t         loc_r, loc_c;
  logic [gbi_pkg::N_W-1:0] n_full, n_sel;

  assign accept = start && state_q == gbi_pkg::F_IDLE;
  assign busy   = state_q != gbi_pkg::F_IDLE;
  assign job_o  = job_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      gbi_pkg::F_IDLE: if (start) begin
        state_d = action_i ? gbi_pkg::F_PUSH : gbi_pkg::F_MUL;
      end
      gbi_pkg::F_MUL: if (cnt_q == 3'd6) begin
        state_d = gbi_pkg::F_PUSH;
      end
      gbi_pkg::F_PUSH: if (!fifo_i.full) begin
        state_d = gbi_pkg::F_IDLE;
      end
      default: state_d = gbi_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    push_o = state_q == gbi_pkg::F_PUSH && !fifo_i.full;
  end

  always_comb begin
    m_sel   = cnt_q < 3'd3 ? (diff_r_q[48] ? 48'd0 : diff_r_q[47:0])
                           : (diff_c_q[48] ? 48'd0 : diff_c_q[47:0]);
    inv_sel = cnt_q < 3'd3 ? cfg_i.inv_h : cfg_i.inv_w;
    csel    = cnt_q < 3'd3 ? cnt_q[1:0] : 2'(cnt_q - 3'd3);
    case (csel)
      2'd0:    chunk = inv_sel[47:32];
      2'd1:    chunk = inv_sel[31:16];
      default: chunk = inv_sel[15:0];
    endcase
    acc_d = ((cnt_q == 3'd0 || cnt_q == 3'd3) ? 96'd0 : {acc_q[79:0], 16'd0})
            + 96'(m_sel * chunk);
    maxr  = gbi_pkg::IDX_W'(cfg_i.rows - 1'b1);
    maxc  = gbi_pkg::IDX_W'(cfg_i.cols - 1'b1);
    loc_r = gbi_pkg::locate(diff_r_q[48], cfg_i.inv_h, acc_q, maxr);
    loc_c = gbi_pkg::locate(diff_c_q[48], cfg_i.inv_w, acc_q, maxc);
    n_full = '0;
    if ({1'b0, first_channel_i} < cfg_i.chans) begin
      n_full = cfg_i.chans - {1'b0, first_channel_i};
    end
    if (channel_span_i < n_full) begin
      n_full = channel_span_i;
    end
    if (n_full > gbi_pkg::N_W'(gbi_pkg::RESULT_LIMIT)) begin
      n_full = gbi_pkg::N_W'(gbi_pkg::RESULT_LIMIT);
    end
    n_sel = n_full == '0 ? gbi_pkg::N_W'(1) : n_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbi_pkg::F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= state_q == gbi_pkg::F_MUL ? 3'(cnt_q + 3'd1) : 3'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      diff_r_q       <= {cfg_i.top[47], cfg_i.top} - {northing_i[47], northing_i};
      diff_c_q       <= {easting_i[47], easting_i} - {cfg_i.west[47], cfg_i.west};
      extra_q        <= extrapolate_i;
      job_q.is_write <= action_i;
      job_q.waddr    <= word_address_i;
      job_q.wdata    <= word_value_i;
      job_q.first    <= first_channel_i;
      job_q.n        <= n_sel;
      job_q.nod_only <= n_full == '0;
      job_q.flags    <= '0;
    end
    if (state_q == gbi_pkg::F_MUL) begin
      acc_q <= acc_d;
      if (cnt_q == 3'd3) begin
        job_q.ri       <= loc_r.idx;
        job_q.dr       <= loc_r.frac;
        job_q.di       <= !loc_r.clamp;
        job_q.flags[0] <= loc_r.clamp;
      end
      if (cnt_q == 3'd6) begin
        job_q.ci       <= loc_c.idx;
        job_q.dc       <= loc_c.frac;
        job_q.dj       <= !loc_c.clamp;
        job_q.flags[1] <= loc_c.clamp;
        if (!extra_q && (job_q.flags[0] || loc_c.clamp)) begin
          job_q.nod_only <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/gbi_fifo.sv =====
module gbi_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  gbi_pkg::job_t         data_i,
  input  logic                  pop_i,
  output gbi_pkg::job_t         data_o,
  output gbi_pkg::fifo_status_t status_o
);

  gbi_pkg::job_t slot_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;

  assign data_o         = slot_q[rp_q];
  assign status_o.full  = cnt_q == 2'd2;
  assign status_o.empty = cnt_q == 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= 2'(cnt_q + {1'b0, push_i} - {1'b0, pop_i});
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= data_i;
    end
  end

endmodule

// ===== rtl/gbi_back.sv =====
module gbi_back #(
  parameter int unsigned GRID_WORDS = gbi_pkg::GRID_WORDS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gbi_pkg::cfg_t         cfg_i,
  input  gbi_pkg::job_t         job_i,
  input  gbi_pkg::fifo_status_t fifo_i,
  output logic                  pop_o,
  output logic                  valid_o,
  output logic signed [31:0]    value_o,
  output logic [3:0]            channel_o,
  output logic [1:0]            bounds_flags_o,
  output logic                  is_nodata_o,
  output logic                  last_o
);

  localparam int unsigned AW = $clog2(GRID_WORDS);

  gbi_pkg::back_state_e state_q, state_d;
  gbi_pkg::job_t        j_q;
  logic [gbi_pkg::CH_W-1:0] k_q;
  logic [2:0]           rc_q;
  logic                 fc_q;
  logic signed [31:0]   cor_q [4];
  logic signed [31:0]   fa, fc, fb, fd;
  logic [gbi_pkg::BASE_W-1:0] tu_q, tl_q, bu_q, bl_q, raddr_w;
  logic [31:0]          mem_q [GRID_WORDS];
  logic [31:0]          rd_q;
  logic [AW-1:0]        raddr, waddr;
  logic                 we;
  logic signed [48:0]   ac_q, bd_q, ac_d, bd_d;
  logic signed [65:0]   x;
  logic signed [31:0]   v_x, v_emit;
  logic                 emit, is_last;
  logic [gbi_pkg::IDX_W-1:0] rl;

  assign is_last = {1'b0, k_q} == 5'(j_q.n - 1'b1);
  assign emit    = state_q == gbi_pkg::B_X || state_q == gbi_pkg::B_NOD;

  always_comb begin
    state_d = state_q;
    case (state_q)
      gbi_pkg::B_IDLE: if (!fifo_i.empty && !job_i.is_write) begin
        state_d = job_i.nod_only ? gbi_pkg::B_NOD : gbi_pkg::B_BASE1;
      end
      gbi_pkg::B_BASE1: state_d = gbi_pkg::B_BASE2;
      gbi_pkg::B_BASE2: state_d = gbi_pkg::B_RD;
      gbi_pkg::B_RD: if (rc_q == 3'd4) begin
        state_d = gbi_pkg::B_FILL;
      end
      gbi_pkg::B_FILL: if (fc_q) begin
        state_d = gbi_pkg::B_AC;
      end
      gbi_pkg::B_AC: state_d = gbi_pkg::B_BD;
      gbi_pkg::B_BD: state_d = gbi_pkg::B_X;
      gbi_pkg::B_X: state_d = is_last ? gbi_pkg::B_IDLE : gbi_pkg::B_RD;
      gbi_pkg::B_NOD: if (is_last) begin
        state_d = gbi_pkg::B_IDLE;
      end
      default: state_d = gbi_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop_o = state_q == gbi_pkg::B_IDLE && !fifo_i.empty;
    we    = pop_o && job_i.is_write && 32'(job_i.waddr) < GRID_WORDS;
    waddr = AW'(32'(job_i.waddr));
  end

  always_comb begin
    raddr_w = (rc_q[1] ? bl_q : bu_q) + gbi_pkg::BASE_W'(k_q)
              + ((rc_q[0] && j_q.dj) ? gbi_pkg::BASE_W'(cfg_i.chans) : '0);
    raddr   = AW'(32'(raddr_w));
    rl      = j_q.ri + gbi_pkg::IDX_W'(j_q.di);
    fa = cor_q[0];
    fc = cor_q[1];
    fb = cor_q[2];
    fd = cor_q[3];
    for (int p = 0; p < gbi_pkg::FILL_STEPS; p++) begin
      if (fa == cfg_i.nod) fa = fb;
      if (fb == cfg_i.nod) fb = fd;
      if (fd == cfg_i.nod) fd = fc;
      if (fc == cfg_i.nod) fc = fa;
    end
    ac_d = 49'(cor_q[0] * 49'sd65536)
           + 49'($signed({1'b0, j_q.dc}) * ($signed({cor_q[1][31], cor_q[1]})
                                           - $signed({cor_q[0][31], cor_q[0]})));
    bd_d = 49'(cor_q[2] * 49'sd65536)
           + 49'($signed({1'b0, j_q.dc}) * ($signed({cor_q[3][31], cor_q[3]})
                                           - $signed({cor_q[2][31], cor_q[2]})));
    x    = 66'(ac_q * 66'sd65536)
           + 66'($signed({1'b0, j_q.dr}) * (66'(bd_q) - 66'(ac_q)))
           + 66'sd2147483648;
    v_x    = cor_q[0] == cfg_i.nod ? cfg_i.nod : x[63:32];
    v_emit = state_q == gbi_pkg::B_X ? v_x : cfg_i.nod;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= job_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbi_pkg::B_IDLE;
      valid_o <= 1'b0;
      k_q     <= '0;
      rc_q    <= '0;
      fc_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_o <= emit;
      fc_q    <= state_q == gbi_pkg::B_FILL ? !fc_q : 1'b0;
      rc_q    <= state_q == gbi_pkg::B_RD ? 3'(rc_q + 3'd1) : 3'd0;
      if (state_q == gbi_pkg::B_IDLE) begin
        k_q <= '0;
      end else if (emit) begin
        k_q <= gbi_pkg::CH_W'(k_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      j_q <= job_i;
    end
    if (state_q == gbi_pkg::B_BASE1) begin
      tu_q <= gbi_pkg::BASE_W'(j_q.ri * cfg_i.cols) + gbi_pkg::BASE_W'(j_q.ci);
      tl_q <= gbi_pkg::BASE_W'(rl * cfg_i.cols) + gbi_pkg::BASE_W'(j_q.ci);
    end
    if (state_q == gbi_pkg::B_BASE2) begin
      bu_q <= gbi_pkg::BASE_W'(tu_q * cfg_i.chans) + gbi_pkg::BASE_W'(j_q.first);
      bl_q <= gbi_pkg::BASE_W'(tl_q * cfg_i.chans) + gbi_pkg::BASE_W'(j_q.first);
    end
    if (state_q == gbi_pkg::B_RD && rc_q != 3'd0) begin
      cor_q[2'(rc_q - 3'd1)] <= rd_q;
    end
    if (state_q == gbi_pkg::B_FILL) begin
      cor_q[0] <= fa;
      cor_q[1] <= fc;
      cor_q[2] <= fb;
      cor_q[3] <= fd;
    end
    if (state_q == gbi_pkg::B_AC) begin
      ac_q <= ac_d;
    end
    if (state_q == gbi_pkg::B_BD) begin
      bd_q <= bd_d;
    end
    if (emit) begin
      value_o        <= v_emit;
      channel_o      <= gbi_pkg::CH_W'(j_q.first + k_q);
      bounds_flags_o <= j_q.flags;
      is_nodata_o    <= v_emit == cfg_i.nod;
      last_o         <= is_last;
    end
  end

endmodule

// ===== rtl/grid_bilinear_interpolator_core.sv =====
// Operation: a grid write is queued and, if its address is in range, written to the grid
// memory when the back pops it; a query gives one result per requested channel, each from four
// corner reads on the single grid memory read port, a nodata fill and three multiply steps;
// nodata-only queries give one result per cycle. A two-entry job queue parts front and back, so
// start is taken again once a query is queued, while the back may still work. Results cannot be stalled.
// Reset: control state and configuration registers reset at once; datapath registers and grid memory are not cleared.
module grid_bilinear_interpolator_core #(
  parameter int unsigned GRID_WORDS = gbi_pkg::GRID_WORDS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               action_i,
  input  logic signed [47:0] northing_i,
  input  logic signed [47:0] easting_i,
  input  logic               extrapolate_i,
  input  logic [3:0]         first_channel_i,
  input  logic [4:0]         channel_span_i,
  input  logic [15:0]        word_address_i,
  input  logic signed [31:0] word_value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i,
  output logic               valid_o,
  output logic signed [31:0] value_o,
  output logic [3:0]         channel_o,
  output logic [1:0]         bounds_flags_o,
  output logic               is_nodata_o,
  output logic               last_o
);

  logic signed [47:0] west_q, top_q;
  logic [47:0]        inv_w_q, inv_h_q;
  logic [12:0]        rows_q, cols_q;
  logic [4:0]         chans_q;
  logic signed [31:0] nod_q;
  gbi_pkg::cfg_t      cfg;
  gbi_pkg::job_t      push_job, head_job;
  gbi_pkg::fifo_status_t fifo_st;
  logic               push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      west_q  <= '0;
      top_q   <= '0;
      inv_w_q <= 48'h0001_0000_0000;
      inv_h_q <= 48'h0001_0000_0000;
      rows_q  <= 13'd1;
      cols_q  <= 13'd1;
      chans_q <= 5'd1;
      nod_q   <= '0;
    end else if (cfg_valid_i) begin
      case (gbi_pkg::cfg_reg_e'(cfg_index_i))
        gbi_pkg::CFG_WEST:   west_q  <= cfg_data_i;
        gbi_pkg::CFG_TOP:    top_q   <= cfg_data_i;
        gbi_pkg::CFG_INV_W:  inv_w_q <= cfg_data_i;
        gbi_pkg::CFG_INV_H:  inv_h_q <= cfg_data_i;
        gbi_pkg::CFG_ROWS:   rows_q  <= cfg_data_i[12:0];
        gbi_pkg::CFG_COLS:   cols_q  <= cfg_data_i[12:0];
        gbi_pkg::CFG_CHANS:  chans_q <= cfg_data_i[4:0];
        gbi_pkg::CFG_NODATA: nod_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.west  = west_q;
    cfg.top   = top_q;
    cfg.inv_w = inv_w_q;
    cfg.inv_h = inv_h_q;
    cfg.nod   = nod_q;
    cfg.rows  = rows_q == '0 ? 13'd1
              : (32'(rows_q) > gbi_pkg::MAX_DIM ? 13'(gbi_pkg::MAX_DIM) : rows_q);
    cfg.cols  = cols_q == '0 ? 13'd1
              : (32'(cols_q) > gbi_pkg::MAX_DIM ? 13'(gbi_pkg::MAX_DIM) : cols_q);
    cfg.chans = chans_q == '0 ? 5'd1
              : (32'(chans_q) > gbi_pkg::MAX_CHANNELS ? 5'(gbi_pkg::MAX_CHANNELS) : chans_q);
  end

  gbi_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg), .start, .busy,
    .action_i, .northing_i, .easting_i, .extrapolate_i, .first_channel_i,
    .channel_span_i, .word_address_i, .word_value_i,
    .fifo_i(fifo_st), .push_o(push), .job_o(push_job)
  );

  gbi_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_job), .pop_i(pop),
    .data_o(head_job), .status_o(fifo_st)
  );

  gbi_back #(.GRID_WORDS(GRID_WORDS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .job_i(head_job), .fifo_i(fifo_st), .pop_o(pop),
    .valid_o, .value_o, .channel_o, .bounds_flags_o, .is_nodata_o, .last_o
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && fifo_st.full)) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && fifo_st.empty)) else $error("job queue underflow");
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o) else $error("result right after last word");
`endif

endmodule
